// ===== src/can_transport_segment_engine_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the CAN transport segment engine checker
// ---------------------------------------------------------------------------
`ifndef CAN_TRANSPORT_SEGMENT_ENGINE_ASSERT_SVH
`define CAN_TRANSPORT_SEGMENT_ENGINE_ASSERT_SVH

// clocked assertion, quiet while reset is held
`define CTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also covers the reset cycles
`define CTS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cts_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_pkg
// Types and constants shared by the CAN transport segment engine.
// ---------------------------------------------------------------------------
package cts_pkg;

  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_SLOT    = 2'd1,
    OP_REQUEST = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_FRAME   = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_STATUS  = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_ABORT   = 3'd4,
    KIND_EMPTY   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    LINK_IDLE  = 3'd0,
    LINK_WAIT  = 3'd1,
    LINK_START = 3'd2,
    LINK_RECV  = 3'd3,
    LINK_FC    = 3'd4
  } link_t;

  // protocol control field, bits 5:4 of byte 0
  localparam logic [1:0] PCI_SF = 2'd0;
  localparam logic [1:0] PCI_FF = 2'd1;
  localparam logic [1:0] PCI_CF = 2'd2;

  localparam logic [7:0] FC_CTS_BYTE = 8'h30;

  localparam logic [2:0] CFG_RX_ID      = 3'd0;
  localparam logic [2:0] CFG_TX_ID      = 3'd1;
  localparam logic [2:0] CFG_BLOCK_SIZE = 3'd2;
  localparam logic [2:0] CFG_ST_MIN     = 3'd3;
  localparam logic [2:0] CFG_PAD_BYTE   = 3'd4;

  localparam logic [10:0] RX_ID_RESET      = 11'h732;
  localparam logic [10:0] TX_ID_RESET      = 11'h731;
  localparam logic [7:0]  BLOCK_SIZE_RESET = 8'd8;
  localparam logic [7:0]  ST_MIN_RESET     = 8'd10;
  localparam logic [7:0]  PAD_BYTE_RESET   = 8'h55;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // one unit of work handed from the front to the back
  typedef struct packed {
    kind_t       kind;
    logic [10:0] id;
    logic [63:0] bytes;
    logic        accepted;
    logic        last;     // for payload runs: mark the final byte
    logic [2:0]  start;    // first byte position of a payload run
    logic [2:0]  cnt;      // number of bytes in a payload run
  } cts_job_t;

  function automatic logic [7:0] byte_at(input logic [63:0] w, input logic [2:0] k);
    logic [7:0] b;
    b = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (k == 3'(i)) begin
        b = w[63 - 8 * i -: 8];
      end
    end
    return b;
  endfunction

endpackage

// ===== src/cts_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_in_if / cts_out_if
// Valid/ready channels for incoming items and for result items.
// ---------------------------------------------------------------------------
interface cts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [10:0] can_id;
  logic [3:0]  frame_len;
  logic [63:0] frame_bytes;

  modport source (output valid, output op, output can_id, output frame_len,
                  output frame_bytes, input ready);
  modport sink   (input valid, input op, input can_id, input frame_len,
                  input frame_bytes, output ready);
endinterface

interface cts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [10:0] out_id;
  logic [63:0] out_bytes;
  logic        accepted;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output kind, output out_id, output out_bytes,
                  output accepted, output payload_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_id, input out_bytes,
                  input accepted, input payload_byte, input last, output ready);
endinterface

// ===== src/can_transport_segment_engine.sv =====
`timescale 1ns / 1ps
// An accepted item goes into the job queue; its first result item leaves
// through the output register. Throughput: one item a cycle enters while
// the job queue has room; results leave at one a cycle while the receiver
// takes them; a received frame gives one per payload byte, up to seven.
// Reset: synchronous, active low; clears link state, queue and output valid.
// ---------------------------------------------------------------------------
// can_transport_segment_engine
// CAN transport client: single-frame request transmit, segmented receive
// with flow control and sequence checking, payload delivered byte-wise.
// ---------------------------------------------------------------------------
module can_transport_segment_engine
  import cts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [10:0] cfg_wdata,
  cts_in_if.sink      in_ch,
  cts_out_if.source   out_ch
);

  logic     q_full, q_empty, push, pop;
  cts_job_t push_job, head;

  cts_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_op          (in_ch.op),
    .in_can_id      (in_ch.can_id),
    .in_frame_len   (in_ch.frame_len),
    .in_frame_bytes (in_ch.frame_bytes),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  cts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  cts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_id           (out_ch.out_id),
    .out_bytes        (out_ch.out_bytes),
    .out_accepted     (out_ch.accepted),
    .out_payload_byte (out_ch.payload_byte),
    .out_last         (out_ch.last)
  );

endmodule

// ===== src/cts_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_front
// Accepts items, runs the link state machine and queues one job per item
// that produces results.
// ---------------------------------------------------------------------------
module cts_front
  import cts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [10:0] in_can_id,
  input  logic [3:0]  in_frame_len,
  input  logic [63:0] in_frame_bytes,
  input  logic        q_full,
  output logic        push,
  output cts_job_t    push_job
);

  logic [10:0] rx_id_r, tx_id_r;
  logic [7:0]  block_size_r, st_min_r, pad_byte_r;

  link_t       state_r, state_nxt;
  logic [3:0]  seq_r, seq_nxt;
  logic [8:0]  countdown_r, countdown_nxt;
  logic [11:0] msg_len_r, msg_len_nxt;
  logic [11:0] recv_r, recv_nxt;
  logic [47:0] req_payload_r, req_payload_nxt;
  logic [2:0]  req_len_r, req_len_nxt;

  logic        in_fire;
  logic        ok;
  logic [7:0]  b0;
  logic [11:0] total;
  logic [11:0] room;
  logic [2:0]  take;
  logic [3:0]  seq_inc;
  logic [8:0]  cd_dec;
  logic [63:0] sf_frame, fc_frame;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign b0       = in_frame_bytes[63:56];
  assign total    = {b0[3:0], in_frame_bytes[55:48]};
  assign room     = (msg_len_r > recv_r) ? (msg_len_r - recv_r) : 12'd0;
  assign take     = (room > 12'd7) ? 3'd7 : room[2:0];
  assign seq_inc  = seq_r + 4'd1;
  assign cd_dec   = countdown_r - 9'd1;
  assign fc_frame = {FC_CTS_BYTE, block_size_r, st_min_r, {5{pad_byte_r}}};

  // single frame carrying the latched request, padded out
  always_comb begin
    sf_frame = '0;
    sf_frame[63:56] = {5'd0, req_len_r};
    for (int i = 1; i <= 6; i++) begin
      sf_frame[63 - 8 * i -: 8] = (3'(i) <= req_len_r) ? req_payload_r[55 - 8 * i -: 8]
                                                        : pad_byte_r;
    end
    sf_frame[7:0] = pad_byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_id_r      <= RX_ID_RESET;
      tx_id_r      <= TX_ID_RESET;
      block_size_r <= BLOCK_SIZE_RESET;
      st_min_r     <= ST_MIN_RESET;
      pad_byte_r   <= PAD_BYTE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RX_ID:      rx_id_r      <= cfg_wdata;
        CFG_TX_ID:      tx_id_r      <= cfg_wdata;
        CFG_BLOCK_SIZE: block_size_r <= cfg_wdata[7:0];
        CFG_ST_MIN:     st_min_r     <= cfg_wdata[7:0];
        CFG_PAD_BYTE:   pad_byte_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LINK_IDLE;
      seq_r       <= '0;
      countdown_r <= '0;
      msg_len_r   <= '0;
      recv_r      <= '0;
      req_len_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      countdown_r <= countdown_nxt;
      msg_len_r   <= msg_len_nxt;
      recv_r      <= recv_nxt;
      req_len_r   <= req_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_payload_r <= req_payload_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    seq_nxt         = seq_r;
    countdown_nxt   = countdown_r;
    msg_len_nxt     = msg_len_r;
    recv_nxt        = recv_r;
    req_payload_nxt = req_payload_r;
    req_len_nxt     = req_len_r;
    ok              = 1'b0;
    push            = 1'b0;
    push_job        = '0;
    push_job.kind   = KIND_ACK;

    if (in_fire) begin
      case (in_op)
        OP_REQUEST: begin
          ok = (state_r == LINK_IDLE) && (in_frame_len >= 4'd1) && (in_frame_len <= 4'd6);
          if (ok) begin
            req_payload_nxt = in_frame_bytes[63:16];
            req_len_nxt     = in_frame_len[2:0];
            state_nxt       = LINK_START;
          end
          push              = 1'b1;
          push_job.kind     = KIND_STATUS;
          push_job.accepted = ok;
        end
        OP_SLOT: begin
          push = 1'b1;
          if (state_r == LINK_START) begin
            push_job.kind  = KIND_FRAME;
            push_job.id    = tx_id_r;
            push_job.bytes = sf_frame;
            state_nxt      = LINK_WAIT;
          end else if (state_r == LINK_FC) begin
            push_job.kind  = KIND_FRAME;
            push_job.id    = tx_id_r;
            push_job.bytes = fc_frame;
            countdown_nxt  = (block_size_r == 8'd0) ? 9'd0 : ({1'b0, block_size_r} + 9'd1);
            state_nxt      = LINK_RECV;
          end else begin
            push_job.kind  = KIND_ACK;
          end
        end
        OP_FRAME: begin
          if (in_can_id == rx_id_r) begin
            case (state_r)
              LINK_WAIT: begin
                if (b0[5:4] == PCI_SF) begin
                  seq_nxt   = '0;
                  state_nxt = LINK_IDLE;
                  push      = 1'b1;
                  if (b0[2:0] == 3'd0) begin
                    push_job.kind = KIND_EMPTY;
                    push_job.last = 1'b1;
                  end else begin
                    push_job.kind  = KIND_PAYLOAD;
                    push_job.bytes = in_frame_bytes;
                    push_job.start = 3'd1;
                    push_job.cnt   = b0[2:0];
                    push_job.last  = 1'b1;
                  end
                end else if (b0[5:4] == PCI_FF) begin
                  if ((in_frame_len == 4'd8) && (total >= 12'd8)) begin
                    msg_len_nxt    = total;
                    recv_nxt       = 12'd6;
                    seq_nxt        = '0;
                    state_nxt      = LINK_FC;
                    push           = 1'b1;
                    push_job.kind  = KIND_PAYLOAD;
                    push_job.bytes = in_frame_bytes;
                    push_job.start = 3'd2;
                    push_job.cnt   = 3'd6;
                  end
                end
              end
              LINK_RECV: begin
                if (b0[5:4] == PCI_CF) begin
                  seq_nxt = seq_inc;
                  if (b0[3:0] != seq_inc) begin
                    state_nxt     = LINK_IDLE;
                    push          = 1'b1;
                    push_job.kind = KIND_ABORT;
                  end else begin
                    recv_nxt = recv_r + {9'd0, take};
                    if (countdown_r > 9'd1) begin
                      countdown_nxt = cd_dec;
                      if (cd_dec == 9'd1) begin
                        state_nxt = LINK_FC;
                      end
                    end
                    // message complete overrides a flow-control round
                    if (recv_nxt >= msg_len_r) begin
                      state_nxt = LINK_IDLE;
                    end
                    push           = (take != 3'd0);
                    push_job.kind  = KIND_PAYLOAD;
                    push_job.bytes = in_frame_bytes;
                    push_job.start = 3'd1;
                    push_job.cnt   = take;
                    push_job.last  = (recv_nxt >= msg_len_r);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/cts_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_queue
// Short job queue between the front and the back.
// ---------------------------------------------------------------------------
module cts_queue
  import cts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cts_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output cts_job_t head
);

  cts_job_t          entry_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == (Q_AW + 1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== src/cts_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_back
// Expands queued jobs into result items, one item a cycle while the output
// is not stalled, through an output register.
// ---------------------------------------------------------------------------
module cts_back
  import cts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cts_job_t    head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [10:0] out_id,
  output logic [63:0] out_bytes,
  output logic        out_accepted,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);

  logic        out_valid_r;
  logic [2:0]  out_kind_r;
  logic [10:0] out_id_r;
  logic [63:0] out_bytes_r;
  logic        out_accepted_r;
  logic [7:0]  out_payload_byte_r;
  logic        out_last_r;
  logic [2:0]  pos_r, pos_nxt;

  logic        issue, is_pl, final_byte;
  logic [2:0]  sel;

  assign is_pl      = (head.kind == KIND_PAYLOAD);
  assign final_byte = (pos_r == (head.cnt - 3'd1));
  assign issue      = !q_empty && (!out_valid_r || out_ready);
  assign pop        = issue && (!is_pl || final_byte);
  assign sel        = head.start + pos_r;

  always_comb begin
    pos_nxt = pos_r;
    if (pop) begin
      pos_nxt = '0;
    end else if (issue) begin
      pos_nxt = pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_kind_r <= head.kind;
      if (is_pl) begin
        out_id_r           <= '0;
        out_bytes_r        <= '0;
        out_accepted_r     <= 1'b0;
        out_payload_byte_r <= byte_at(head.bytes, sel);
        out_last_r         <= head.last && final_byte;
      end else begin
        out_id_r           <= head.id;
        out_bytes_r        <= head.bytes;
        out_accepted_r     <= head.accepted;
        out_payload_byte_r <= 8'h00;
        out_last_r         <= head.last;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_id           = out_id_r;
  assign out_bytes        = out_bytes_r;
  assign out_accepted     = out_accepted_r;
  assign out_payload_byte = out_payload_byte_r;
  assign out_last         = out_last_r;

endmodule

// ===== src/cts_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cts_checker
// Port-level checks on the result channel of the transport engine.
// ---------------------------------------------------------------------------
`include "can_transport_segment_engine_assert.svh"

module cts_checker
  import cts_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_payload_byte,
  input logic       out_last
);

  `CTS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_payload_byte) && $stable(out_last), "result item changed while stalled")
  `CTS_ASSERT(a_byte_zero, out_valid && out_kind != KIND_PAYLOAD |-> out_payload_byte == 8'h00, "payload byte set on a non-payload item")
  `CTS_ASSERT(a_abort_not_last, out_valid && out_kind == KIND_ABORT |-> !out_last, "abort item marked last")
  `CTS_ASSERT(a_empty_last, out_valid && out_kind == KIND_EMPTY |-> out_last, "empty message item not marked last")
  `CTS_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid straight after reset")

endmodule

bind can_transport_segment_engine cts_checker u_cts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_payload_byte (out_ch.payload_byte),
  .out_last         (out_ch.last)
);
